### rtl/tks_pkg.sv
// Shared types, constants and helpers for the top-k sorted insertion block.
// No dependencies; every other file in rtl/ imports this package.
package tks_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam logic [7:0] KEEP_RESET = 8'd100;
    // Number of cells merged by one first-level OR group of the read tree.
    localparam int RD_GROUP = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] score;
        logic [6:0]         index;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [7:0]         held_count;
        logic signed [31:0] read_value;
        logic               read_valid;
    } t_out;

    // Per-cell control broadcast from the top level.
    typedef struct packed {
        logic take;      // the current insert enters the list
        logic occupied;  // this cell holds a live entry
        logic in_limit;  // this cell lies below the active limit
        logic sel;       // this cell is the target of a read
    } t_cell_ctl;

    // Per-cell compare status returned to the top level.
    typedef struct packed {
        logic gt;        // the new score belongs at or above this cell
        logic gt_lim;    // same, restricted to cells below the limit
    } t_cell_stat;

    // Active list length: keep_count saturated at the cell count.
    function automatic logic [7:0] limit_of(input logic [7:0] keep, input int cap);
        logic [7:0] lim;
        lim = keep;
        if (cap < 256 && int'(keep) > cap) begin
            lim = 8'(cap);
        end
        return lim;
    endfunction

endpackage

### rtl/top_k_sorted_insert_top.sv
// Top level of the top-k sorted insertion block: a row of compare-and-shift cells plus read tree.
// Depends on tks_pkg, tks_cell and tks_rd_tree.
//
// An insert is accepted while busy is low, and its result strobes on o_done in the next cycle;
// inserts may follow back to back at one per cycle while no read holds busy, since every cell
// compares and shifts in parallel. A read gathers the selected cell through a registered OR
// tree: busy is high in the cycle after the read is accepted, and the result strobes on o_done
// in the cycle after that. Results cannot be stalled and appear in acceptance order. The list
// storage needs no clearing after reset; only the entry count is cleared. keep_count may be
// rewritten while idle, and the list is cut to the new limit at once.
module top_k_sorted_insert_top import tks_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_in        i_in,
    output logic       busy,
    output logic       o_done,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_keep;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic       r_rd_pend;
    logic       r_rd_valid;
    logic       r_done;
    t_out       r_out;

    logic [7:0] lim;
    logic [7:0] cfg_lim;
    logic       acc;
    logic       ins;
    logic       rd;
    logic       take;
    logic       rd_valid;
    logic [31:0] tree_val;

    logic [CAPACITY-1:0][31:0] vals;
    logic [CAPACITY-1:0][31:0] rdv;
    logic [CAPACITY-1:0]       gt;
    logic [CAPACITY-1:0]       gt_lim;

    assign busy    = r_rd_pend;
    assign acc     = start && !busy;
    assign ins     = acc && (i_in.cmd == CMD_INSERT);
    assign rd      = acc && (i_in.cmd == CMD_READ);
    assign lim     = limit_of(r_keep, CAPACITY);
    assign cfg_lim = limit_of(i_cfg_data, CAPACITY);
    assign take    = ins && (|gt_lim);
    assign rd_valid = 32'(i_in.index) < 32'(r_count);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_ctl  ctl;
        t_cell_stat stat;
        logic [31:0] prev_val;
        logic        prev_gt;

        assign ctl.take     = take;
        assign ctl.occupied = 32'(i) < 32'(r_count);
        assign ctl.in_limit = 32'(i) < 32'(lim);
        assign ctl.sel      = rd && (32'(i) == 32'(i_in.index));

        if (i == 0) begin : g_head
            assign prev_val = 32'd0;
            assign prev_gt  = 1'b0;
        end else begin : g_body
            assign prev_val = vals[i-1];
            assign prev_gt  = gt[i-1];
        end

        tks_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_score    (i_in.score),
            .i_prev_val (prev_val),
            .i_prev_gt  (prev_gt),
            .o_val      (vals[i]),
            .o_rd       (rdv[i]),
            .o_stat     (stat)
        );

        assign gt[i]     = stat.gt;
        assign gt_lim[i] = stat.gt_lim;
    end

    tks_rd_tree #(.CAPACITY(CAPACITY)) u_rd_tree (
        .i_clk  (i_clk),
        .i_en   (rd),
        .i_vals (rdv),
        .o_val  (tree_val)
    );

    always_comb begin
        n_count = r_count;
        if (i_cfg_we) begin
            n_count = (r_count > cfg_lim) ? cfg_lim : r_count;
        end else if (take && (r_count < lim)) begin
            n_count = r_count + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep    <= KEEP_RESET;
            r_count   <= 8'd0;
            r_rd_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep <= i_cfg_data;
            end
            r_count   <= n_count;
            r_rd_pend <= rd;
            r_done    <= ins || r_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd) begin
            r_rd_valid <= rd_valid;
        end
        if (ins) begin
            r_out.accepted   <= take;
            r_out.held_count <= n_count;
            r_out.read_value <= 32'sd0;
            r_out.read_valid <= 1'b0;
        end else if (r_rd_pend) begin
            r_out.accepted   <= 1'b0;
            r_out.held_count <= r_count;
            r_out.read_value <= r_rd_valid ? $signed(tree_val) : 32'sd0;
            r_out.read_valid <= r_rd_valid;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    // The entry count never passes the active limit.
    a_count_le_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lim)
        else $error("entry count above limit");

    // A read in flight always produces its result in the following cycle.
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> o_done)
        else $error("read result missing");

    // An accepted insert into a list below its limit grows the list by one.
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_count < lim) && !i_cfg_we) |=> (r_count == $past(r_count) + 8'd1))
        else $error("count did not grow on insert");

    // A result never reports both an accepted insert and a valid read.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_out.accepted && o_out.read_valid))
        else $error("result mixes insert and read");

endmodule

### rtl/tks_cell.sv
// One compare-and-shift cell of the sorted list.
// Depends on tks_pkg for the control and status structs.
module tks_cell import tks_pkg::*; (
    input  logic        i_clk,
    input  t_cell_ctl   i_ctl,
    input  logic [31:0] i_score,
    input  logic [31:0] i_prev_val,
    input  logic        i_prev_gt,
    output logic [31:0] o_val,
    output logic [31:0] o_rd,
    output t_cell_stat  o_stat
);

    logic [31:0] r_val;
    logic        gt;

    // An empty cell always yields to the new score; a live one only to a strictly larger one,
    // so equal scores keep their older entries ahead.
    assign gt = !i_ctl.occupied || ($signed(i_score) > $signed(r_val));

    assign o_stat.gt     = gt;
    assign o_stat.gt_lim = gt && i_ctl.in_limit;
    assign o_val         = r_val;
    assign o_rd          = i_ctl.sel ? r_val : 32'd0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take && gt) begin
            r_val <= i_prev_gt ? i_prev_val : i_score;
        end
    end

endmodule

### rtl/tks_rd_tree.sv
// Registered OR tree that gathers the one selected cell value for a read.
// Depends on tks_pkg for the group size.
module tks_rd_tree import tks_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [CAPACITY-1:0][31:0] i_vals,
    output logic [31:0]              o_val
);

    localparam int NGRP = (CAPACITY + RD_GROUP - 1) / RD_GROUP;

    logic [NGRP*RD_GROUP-1:0][31:0] padded;
    logic [NGRP-1:0][31:0]          n_grp;
    logic [NGRP-1:0][31:0]          r_grp;

    always_comb begin
        padded = '0;
        padded[CAPACITY-1:0] = i_vals;
    end

    always_comb begin
        n_grp = '0;
        for (int g = 0; g < NGRP; g++) begin
            for (int j = 0; j < RD_GROUP; j++) begin
                n_grp[g] = n_grp[g] | padded[g*RD_GROUP + j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_val = 32'd0;
        for (int g = 0; g < NGRP; g++) begin
            o_val = o_val | r_grp[g];
        end
    end

endmodule
